@@ hw/rtl/gif_tag_unpacker_macros.svh @@
`ifndef GIF_TAG_UNPACKER_MACROS_SVH
`define GIF_TAG_UNPACKER_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define GTU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gif tag unpacker check failed");

// next-cycle implication, held off while reset is asserted
`define GTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gif tag unpacker check failed");

`endif

@@ hw/rtl/gtu_pkg.sv @@
package gtu_pkg;

    localparam int unsigned WordW    = 64;
    localparam int unsigned RegIdxW  = 4;
    localparam int unsigned LoopW    = 15;
    localparam int unsigned PrimW    = 11;
    localparam int unsigned InDataW  = 2 * WordW;
    // reg_addr, word_lo, word_hi, transfer_done, padded to whole bytes
    localparam int unsigned OutUsedW = RegIdxW + 2 * WordW + 1;
    localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

    // tag bit positions in the low half
    localparam int unsigned TagEopBit    = 15;
    localparam int unsigned TagPrimEnBit = 46;
    localparam int unsigned TagPrimLsb   = 47;
    localparam int unsigned TagFmtLsb    = 58;
    localparam int unsigned TagNregLsb   = 60;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PRIM   = 2'd0;
    localparam t_kind KIND_PACKED = 2'd1;
    localparam t_kind KIND_IMAGE  = 2'd2;
    localparam t_kind KIND_ERROR  = 2'd3;

    typedef logic [1:0] t_fmt;
    localparam t_fmt FMT_PACKED = 2'd0;
    localparam t_fmt FMT_IMAGE  = 2'd2;

    localparam logic CMD_DATA       = 1'b0;
    localparam logic CMD_SOFT_RESET = 1'b1;

    typedef struct packed {
        t_kind              kind;
        logic [RegIdxW-1:0] reg_addr;
        logic [WordW-1:0]   word_lo;
        logic [WordW-1:0]   word_hi;
        logic               done;
        logic               last;
    } t_result;

    // results caused by one word, at most two
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_batch;

endpackage

@@ hw/rtl/gtu_in_reg.sv @@
module gtu_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic [gtu_pkg::WordW-1:0]    i_lo,
    input  logic [gtu_pkg::WordW-1:0]    i_hi,
    output logic                         o_valid,
    input  logic                         i_take,
    output logic                         o_cmd,
    output logic [gtu_pkg::WordW-1:0]    o_lo,
    output logic [gtu_pkg::WordW-1:0]    o_hi
);

    logic                      r_valid;
    logic                      r_cmd;
    logic [gtu_pkg::WordW-1:0] r_lo;
    logic [gtu_pkg::WordW-1:0] r_hi;
    logic                      w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
            r_lo  <= i_lo;
            r_hi  <= i_hi;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

endmodule

@@ hw/rtl/gtu_core.sv @@
module gtu_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic                      i_cmd,
    input  logic [gtu_pkg::WordW-1:0] i_lo,
    input  logic [gtu_pkg::WordW-1:0] i_hi,
    input  logic                      i_path_mask,
    output gtu_pkg::t_batch           o_batch
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PACKED = 2'd1,
        MODE_IMAGE  = 2'd2
    } t_mode;

    t_mode                             r_mode,  n_mode;
    logic [gtu_pkg::LoopW-1:0]         r_loops, n_loops;
    logic [gtu_pkg::RegIdxW-1:0]       r_pos,   n_pos;
    logic [gtu_pkg::RegIdxW:0]         r_total, n_total;
    logic [gtu_pkg::WordW-1:0]         r_list,  n_list;
    logic                              r_eop,   n_eop;
    logic                              r_done,  n_done;

    logic [gtu_pkg::LoopW-1:0]         w_nloop;
    logic                              w_tag_eop;
    logic                              w_prim_en;
    logic [gtu_pkg::PrimW-1:0]         w_prim;
    gtu_pkg::t_fmt                     w_fmt;
    logic [gtu_pkg::RegIdxW-1:0]       w_nregs;
    logic [gtu_pkg::LoopW-1:0]         w_loop_dec;
    logic [gtu_pkg::RegIdxW:0]         w_pos_inc;
    logic [gtu_pkg::RegIdxW-1:0]       w_idx;
    gtu_pkg::t_result                  w_prim_res;
    gtu_pkg::t_result                  w_err_res;
    gtu_pkg::t_batch                   w_batch;

    assign w_nloop    = i_lo[gtu_pkg::LoopW-1:0];
    assign w_tag_eop  = i_lo[gtu_pkg::TagEopBit];
    assign w_prim_en  = i_lo[gtu_pkg::TagPrimEnBit];
    assign w_prim     = i_lo[gtu_pkg::TagPrimLsb +: gtu_pkg::PrimW];
    assign w_fmt      = i_lo[gtu_pkg::TagFmtLsb +: 2];
    assign w_nregs    = i_lo[gtu_pkg::TagNregLsb +: gtu_pkg::RegIdxW];
    assign w_loop_dec = r_loops - gtu_pkg::LoopW'(1);
    assign w_pos_inc  = {1'b0, r_pos} + (gtu_pkg::RegIdxW+1)'(1);
    assign w_idx      = r_list[{r_pos, 2'b00} +: gtu_pkg::RegIdxW];

    always_comb begin
        w_prim_res           = '0;
        w_prim_res.kind      = gtu_pkg::KIND_PRIM;
        w_prim_res.word_lo   = {{(gtu_pkg::WordW-gtu_pkg::PrimW){1'b0}}, w_prim};
        w_err_res            = '0;
        w_err_res.kind       = gtu_pkg::KIND_ERROR;
    end

    always_comb begin
        n_mode  = r_mode;
        n_loops = r_loops;
        n_pos   = r_pos;
        n_total = r_total;
        n_list  = r_list;
        n_eop   = r_eop;
        n_done  = r_done;
        w_batch = '0;

        if (i_cmd == gtu_pkg::CMD_SOFT_RESET) begin
            n_mode  = MODE_IDLE;
            n_loops = '0;
            n_pos   = '0;
            n_total = '0;
            n_list  = '0;
            n_eop   = 1'b0;
            n_done  = 1'b0;
        end else if (!i_path_mask) begin
            unique case (r_mode)
                MODE_PACKED: begin
                    w_batch.count          = 2'd1;
                    w_batch.res0.kind      = gtu_pkg::KIND_PACKED;
                    w_batch.res0.reg_addr  = w_idx;
                    w_batch.res0.word_lo   = i_lo;
                    w_batch.res0.word_hi   = i_hi;
                    n_pos                  = w_pos_inc[gtu_pkg::RegIdxW-1:0];
                    if (w_pos_inc >= r_total) begin
                        n_pos   = '0;
                        n_loops = w_loop_dec;
                        if (w_loop_dec == '0) begin
                            n_mode = MODE_IDLE;
                            if (r_eop) begin
                                n_done = 1'b1;
                            end
                        end
                    end
                end
                MODE_IMAGE: begin
                    w_batch.count        = 2'd2;
                    w_batch.res0.kind    = gtu_pkg::KIND_IMAGE;
                    w_batch.res0.word_lo = i_lo;
                    w_batch.res1.kind    = gtu_pkg::KIND_IMAGE;
                    w_batch.res1.word_lo = i_hi;
                    n_loops              = w_loop_dec;
                    if (w_loop_dec == '0) begin
                        n_mode = MODE_IDLE;
                        if (r_eop) begin
                            n_done = 1'b1;
                        end
                    end
                end
                default: begin
                    // word is a tag
                    n_mode = MODE_IDLE;
                    if (w_nloop != '0) begin
                        if (w_prim_en) begin
                            w_batch.count = 2'd1;
                            w_batch.res0  = w_prim_res;
                        end
                        if (w_fmt == gtu_pkg::FMT_PACKED || w_fmt == gtu_pkg::FMT_IMAGE) begin
                            n_mode  = (w_fmt == gtu_pkg::FMT_PACKED) ? MODE_PACKED
                                                                     : MODE_IMAGE;
                            n_loops = w_nloop;
                            n_pos   = '0;
                            // a count of zero means sixteen registers
                            n_total = {(w_nregs == '0), w_nregs};
                            n_list  = i_hi;
                            n_eop   = w_tag_eop;
                        end else if (w_prim_en) begin
                            w_batch.count = 2'd2;
                            w_batch.res1  = w_err_res;
                        end else begin
                            w_batch.count = 2'd1;
                            w_batch.res0  = w_err_res;
                        end
                    end
                end
            endcase
        end

        w_batch.res0.done = n_done;
        w_batch.res1.done = n_done;
        w_batch.res0.last = (w_batch.count == 2'd1);
        w_batch.res1.last = (w_batch.count == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_loops <= '0;
            r_pos   <= '0;
            r_total <= '0;
            r_list  <= '0;
            r_eop   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_loops <= n_loops;
            r_pos   <= n_pos;
            r_total <= n_total;
            r_list  <= n_list;
            r_eop   <= n_eop;
            r_done  <= n_done;
        end
    end

    assign o_batch = w_batch;

endmodule

@@ hw/rtl/gtu_out_buf.sv @@
module gtu_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gtu_pkg::t_batch  i_batch,
    input  logic             i_ready,
    output logic             o_valid,
    output gtu_pkg::t_result o_head,
    output logic             o_can_load
);

    logic [1:0]       r_cnt;
    gtu_pkg::t_result r_slot0;
    gtu_pkg::t_result r_slot1;
    logic             w_pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_head     = r_slot0;
    assign w_pop      = o_valid && i_ready;
    // buffer is free once its last word leaves this cycle
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_batch.res0;
            r_slot1 <= i_batch.res1;
        end else if (w_pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

@@ hw/rtl/gif_tag_unpacker.sv @@
// path: an accepted input word is registered in gtu_in_reg, its results in gtu_out_buf
// throughput: one input word per cycle while m_axis_tready is high and each word
// gives at most one result; image data words give two results each on the one output,
// so the next word waits; s_axis_tready drops while the 2-entry result buffer drains
// reset: i_rst_n synchronous active low, clears all control state and path_mask
// a soft reset command clears the unpack state and done flag but keeps path_mask
`include "gif_tag_unpacker_macros.svh"

module gif_tag_unpacker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: path_mask
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [gtu_pkg::InDataW-1:0]  s_axis_tdata,  // data_lo, data_hi
    input  logic [0:0]                   s_axis_tuser,  // command
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [gtu_pkg::OutDataW-1:0] m_axis_tdata,  // reg_addr, word_lo, word_hi,
                                                        // transfer_done, zero pad
    output logic [1:0]                   m_axis_tuser,  // kind
    output logic                         m_axis_tlast
);

    logic                      r_path_mask;
    logic                      w_in_valid;
    logic                      w_in_cmd;
    logic [gtu_pkg::WordW-1:0] w_in_lo;
    logic [gtu_pkg::WordW-1:0] w_in_hi;
    logic                      w_can_load;
    logic                      w_fire;
    logic                      w_soft_fire;
    gtu_pkg::t_batch           w_batch;
    gtu_pkg::t_result          w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_mask <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_path_mask <= i_cfg_data;
        end
    end

    gtu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser[0]),
        .i_lo    (s_axis_tdata[gtu_pkg::WordW-1:0]),
        .i_hi    (s_axis_tdata[gtu_pkg::InDataW-1:gtu_pkg::WordW]),
        .o_valid (w_in_valid),
        .i_take  (w_fire),
        .o_cmd   (w_in_cmd),
        .o_lo    (w_in_lo),
        .o_hi    (w_in_hi)
    );

    assign w_fire      = w_in_valid && w_can_load;
    assign w_soft_fire = w_fire && (w_in_cmd == gtu_pkg::CMD_SOFT_RESET);

    gtu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_cmd       (w_in_cmd),
        .i_lo        (w_in_lo),
        .i_hi        (w_in_hi),
        .i_path_mask (r_path_mask),
        .o_batch     (w_batch)
    );

    gtu_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_batch    (w_batch),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_head     (w_head),
        .o_can_load (w_can_load)
    );

    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;
    assign m_axis_tdata = {{(gtu_pkg::OutDataW-gtu_pkg::OutUsedW){1'b0}},
                           w_head.done, w_head.word_hi, w_head.word_lo, w_head.reg_addr};

    `GTU_ASSERT_IMPL(a_soft_reset_silent, i_clk, i_rst_n, w_soft_fire, w_batch.count == 2'd0)
    `GTU_ASSERT_IMPL(a_batch_bounded, i_clk, i_rst_n, w_fire, w_batch.count != 2'd3)
    `GTU_ASSERT_IMPL(a_ready_when_drained, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `GTU_ASSERT_NEXT(a_results_shown, i_clk, i_rst_n, w_fire && w_batch.count != 2'd0, m_axis_tvalid)

endmodule
